/* rtl/run_length_byte_encoder_core_assert.svh */
// Assertion macros shared by the encoder RTL.
`ifndef RUN_LENGTH_BYTE_ENCODER_CORE_ASSERT_SVH
`define RUN_LENGTH_BYTE_ENCODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLBE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("encoder assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RLBE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("encoder assertion failed");

`endif

/* rtl/rlbe_pkg.sv */
package rlbe_pkg;

    localparam int CHUNK_BYTES = 4096;
    localparam int COUNT_W     = $clog2(CHUNK_BYTES + 1);
    localparam int MAX_RESULTS = 4;
    localparam int OUT_DEPTH   = 8;
    localparam int PTR_W       = $clog2(OUT_DEPTH);
    localparam int FILL_W      = $clog2(OUT_DEPTH + 1);

    localparam logic [1:0] CFG_VISIBLE_MASK = 2'd0;
    localparam logic [1:0] CFG_REPEAT_MASK  = 2'd1;
    localparam logic [1:0] CFG_AIR_CODE     = 2'd2;

    localparam logic [15:0] HEADER_SIZE = 16'd2;
    localparam logic [7:0]  MAX_EXTRA   = 8'hff;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_body;
        logic [15:0] total_size;
        logic        only_air;
        logic        last;
    } rlbe_item_t;

    function automatic rlbe_item_t body_item(logic [7:0] value);
        rlbe_item_t item;
        item.out_byte   = value;
        item.is_body    = 1'b1;
        item.total_size = '0;
        item.only_air   = 1'b0;
        item.last       = 1'b0;
        return item;
    endfunction

endpackage

/* rtl/run_length_byte_encoder_core.sv */
// Run-length byte encoder. One input byte is accepted per clock cycle; its results are
// computed in the same cycle and written into an 8-entry result queue, which delivers one
// result item per cycle while m_tready is high. The input is held off while fewer than
// four queue entries are free, so the sustained rate is one byte per cycle as long as
// the chunk yields on average no more than one result per byte, and the output rate of
// one item per cycle bounds it otherwise. Configuration writes are always taken.
module run_length_byte_encoder_core import rlbe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_byte, [23:8] total_size, [24] only_air
    output logic        m_tuser,   // is_body
    output logic        m_tlast,   // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0] visible_mask_reg;
    logic [7:0] repeat_mask_reg;
    logic [7:0] air_code_reg;

    logic               run_open_reg, run_open_next;
    logic [7:0]         run_type_reg, run_type_next;
    logic [7:0]         run_extra_reg, run_extra_next;
    logic [15:0]        size_count_reg, size_count_next;
    logic               all_air_reg, all_air_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;

    rlbe_item_t         queue_reg [OUT_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FILL_W-1:0]  fill_reg, fill_next;

    rlbe_item_t         items [MAX_RESULTS];
    logic [2:0]         n_items;
    logic               in_fire, out_fire;
    logic [7:0]         masked;
    logic               chunk_end, extend, air_now;
    logic [COUNT_W-1:0] count_inc;
    logic [7:0]         cur_type, cur_extra;
    logic [16:0]        size_sum;
    logic [15:0]        size_sat;
    rlbe_item_t         head;

    assign cfg_ready = 1'b1;
    assign s_tready  = (fill_reg <= FILL_W'(OUT_DEPTH - MAX_RESULTS));
    assign in_fire   = s_tvalid && s_tready;
    assign m_tvalid  = (fill_reg != '0);
    assign out_fire  = m_tvalid && m_tready;

    assign head    = queue_reg[rd_ptr_reg];
    assign m_tdata = {7'd0, head.only_air, head.total_size, head.out_byte};
    assign m_tuser = head.is_body;
    assign m_tlast = head.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            visible_mask_reg <= 8'd128;
            repeat_mask_reg  <= 8'd128;
            air_code_reg     <= 8'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_VISIBLE_MASK: visible_mask_reg <= cfg_data;
                CFG_REPEAT_MASK:  repeat_mask_reg  <= cfg_data;
                CFG_AIR_CODE:     air_code_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        masked    = s_tdata & ~visible_mask_reg;
        count_inc = byte_count_reg + COUNT_W'(1);
        chunk_end = s_tlast || (count_inc >= COUNT_W'(CHUNK_BYTES));
        air_now   = all_air_reg && (masked == air_code_reg);
        extend    = run_open_reg && (masked == run_type_reg) && (run_extra_reg != MAX_EXTRA);

        for (int k = 0; k < MAX_RESULTS; k++) begin
            items[k] = '0;
        end
        n_items = '0;

        if (run_open_reg && !extend) begin
            if (run_extra_reg == 8'd0) begin
                items[n_items[1:0]] = body_item(run_type_reg);
                n_items = n_items + 3'd1;
            end else begin
                items[n_items[1:0]] = body_item(run_type_reg | repeat_mask_reg);
                n_items = n_items + 3'd1;
                items[n_items[1:0]] = body_item(run_extra_reg);
                n_items = n_items + 3'd1;
            end
        end

        cur_type  = extend ? run_type_reg : masked;
        cur_extra = extend ? (run_extra_reg + 8'd1) : 8'd0;

        if (chunk_end) begin
            if (cur_extra == 8'd0) begin
                items[n_items[1:0]] = body_item(cur_type);
                n_items = n_items + 3'd1;
            end else begin
                items[n_items[1:0]] = body_item(cur_type | repeat_mask_reg);
                n_items = n_items + 3'd1;
                items[n_items[1:0]] = body_item(cur_extra);
                n_items = n_items + 3'd1;
            end
        end

        size_sum = {1'b0, size_count_reg} + {14'd0, n_items};
        size_sat = size_sum[16] ? 16'hffff : size_sum[15:0];

        if (chunk_end) begin
            items[n_items[1:0]].out_byte   = 8'd0;
            items[n_items[1:0]].is_body    = 1'b0;
            items[n_items[1:0]].total_size = air_now ? HEADER_SIZE : size_sat;
            items[n_items[1:0]].only_air   = air_now;
            items[n_items[1:0]].last       = 1'b1;
            n_items = n_items + 3'd1;
        end

        if (!in_fire) begin
            n_items = '0;
        end

        run_open_next   = run_open_reg;
        run_type_next   = run_type_reg;
        run_extra_next  = run_extra_reg;
        size_count_next = size_count_reg;
        all_air_next    = all_air_reg;
        byte_count_next = byte_count_reg;
        if (in_fire) begin
            if (chunk_end) begin
                run_open_next   = 1'b0;
                run_type_next   = 8'd0;
                run_extra_next  = 8'd0;
                size_count_next = HEADER_SIZE;
                all_air_next    = 1'b1;
                byte_count_next = '0;
            end else begin
                run_open_next   = 1'b1;
                run_type_next   = cur_type;
                run_extra_next  = cur_extra;
                size_count_next = size_sat;
                all_air_next    = air_now;
                byte_count_next = count_inc;
            end
        end

        fill_next = fill_reg + FILL_W'(n_items) - FILL_W'(out_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_open_reg   <= 1'b0;
            run_type_reg   <= 8'd0;
            run_extra_reg  <= 8'd0;
            size_count_reg <= HEADER_SIZE;
            all_air_reg    <= 1'b1;
            byte_count_reg <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fill_reg       <= '0;
        end else begin
            run_open_reg   <= run_open_next;
            run_type_reg   <= run_type_next;
            run_extra_reg  <= run_extra_next;
            size_count_reg <= size_count_next;
            all_air_reg    <= all_air_next;
            byte_count_reg <= byte_count_next;
            wr_ptr_reg     <= wr_ptr_reg + PTR_W'(n_items);
            rd_ptr_reg     <= rd_ptr_reg + PTR_W'(out_fire);
            fill_reg       <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (3'(k) < n_items) begin
                queue_reg[wr_ptr_reg + PTR_W'(k)] <= items[k];
            end
        end
    end

`include "run_length_byte_encoder_core_assert.svh"

    `RLBE_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FILL_W'(OUT_DEPTH))
    `RLBE_ASSERT_NOW(a_air_size, m_tvalid && m_tdata[24], (m_tdata[23:8] == HEADER_SIZE) && m_tlast && !m_tuser)
    `RLBE_ASSERT_NEXT(a_chunk_clear, s_tvalid && s_tready && s_tlast, (byte_count_reg == '0) && !run_open_reg)
    `RLBE_ASSERT_NEXT(a_drain, out_fire && (fill_reg == FILL_W'(1)) && !in_fire, !m_tvalid)

endmodule
